[sv/dns_name_label_encoder_core_assert.svh]
// Assertion macros shared by the checker files of the label encoder.
`ifndef DNS_NAME_LABEL_ENCODER_CORE_ASSERT_SVH
`define DNS_NAME_LABEL_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define DNLE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define DNLE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/dnle_pkg.sv]
// Package with the types, constants and character classes of the label encoder.
package dnle_pkg;

   localparam int MAX_LABEL   = 63;
   localparam int LABEL_CNT_W = $clog2(MAX_LABEL + 1);
   localparam int RING_AW     = 7;
   localparam int RING_DEPTH  = 1 << RING_AW;
   localparam int RING_PTR_W  = RING_AW + 1;
   localparam int CMD_AW      = 2;
   localparam int CMD_DEPTH   = 1 << CMD_AW;
   localparam int CMD_PTR_W   = CMD_AW + 1;

   localparam logic [7:0] DOT_CHAR    = 8'h2E;
   localparam logic [7:0] HYPHEN_CHAR = 8'h2D;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } dnle_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       name_error;
   } dnle_rsp_type;

   typedef struct packed {
      logic [LABEL_CNT_W-1:0] len;
      logic                   is_final;
      logic                   err;
   } dnle_cmd_type;

   typedef struct packed {
      logic               en;
      logic [RING_AW-1:0] addr;
      logic [7:0]         data;
   } dnle_wr_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

endpackage

[sv/dns_name_label_encoder_core.sv]
// Top level of the DNS name label encoder: front end, command queue, byte ring, back end.
// The front end accepts the bytes of a dotted name, checks the letter-digit-hyphen
// rule and writes label characters into a 128-byte ring. A closed valid label is
// queued as a command. The back end takes a command, then gives one result word per
// cycle while the result side pops: a length byte followed by the label's characters,
// or a single error word at the end of a bad name. As the back end adds a length byte
// and a command step to every label, a run of short labels can outpace it. The input
// side reports full when the four-entry command queue or the ring is full, which
// happens when the result side is held off or short labels pile up.
module dns_name_label_encoder_core
   import dnle_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  dnle_req_type req_word,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output dnle_rsp_type rsp_word
);

   logic                  cmd_push;
   logic                  cmd_full;
   logic                  cmd_pop;
   logic                  cmd_empty;
   dnle_cmd_type          cmd_in;
   dnle_cmd_type          cmd_out;
   dnle_wr_type           wr;
   logic [RING_PTR_W-1:0] rd_ptr;
   logic [RING_AW-1:0]    rd_addr;
   logic [7:0]            rd_data;

   dnle_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_word (req_word),
      .rd_ptr   (rd_ptr),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd      (cmd_in),
      .wr       (wr)
   );

   dnle_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd_in),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .empty    (cmd_empty),
      .pop_cmd  (cmd_out)
   );

   dnle_label_ram u_label_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dnle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_out),
      .cmd_pop   (cmd_pop),
      .rd_ptr    (rd_ptr),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

[sv/dnle_label_ram.sv]
// Byte ring memory that holds label characters between front and back.
module dnle_label_ram
   import dnle_pkg::*;
(
   input  logic               clock,
   input  dnle_wr_type        wr,
   input  logic [RING_AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem [RING_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/dnle_cmd_fifo.sv]
// Short queue of label commands from the front to the back.
module dnle_cmd_fifo
   import dnle_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  dnle_cmd_type push_cmd,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output dnle_cmd_type pop_cmd
);

   dnle_cmd_type entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wptr_ff, wptr_in;
   logic [CMD_PTR_W-1:0] rptr_ff, rptr_in;

   assign full    = (wptr_ff - rptr_ff) == CMD_PTR_W'(CMD_DEPTH);
   assign empty   = wptr_ff == rptr_ff;
   assign pop_cmd = entry_ff[rptr_ff[CMD_AW-1:0]];
   assign wptr_in = (push && !full) ? wptr_ff + CMD_PTR_W'(1) : wptr_ff;
   assign rptr_in = (pop && !empty) ? rptr_ff + CMD_PTR_W'(1) : rptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wptr_ff[CMD_AW-1:0]] <= push_cmd;
      end
   end

endmodule

[sv/dnle_front.sv]
// Front end: accepts name bytes, checks each label and stores its characters.
module dnle_front
   import dnle_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  dnle_req_type          req_word,
   input  logic [RING_PTR_W-1:0] rd_ptr,
   input  logic                  cmd_full,
   output logic                  cmd_push,
   output dnle_cmd_type          cmd,
   output dnle_wr_type           wr
);

   logic [LABEL_CNT_W-1:0] count_ff, count_in;
   logic                   bad_ff, bad_in;
   logic                   lastld_ff, lastld_in;
   logic                   sticky_ff, sticky_in;
   logic [RING_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RING_PTR_W-1:0]  start_ff, start_in;

   logic                   accept;
   logic [7:0]             c;
   logic                   is_let;
   logic                   is_ld;
   logic                   is_dot;
   logic                   room;
   logic                   tb_bad;
   logic [LABEL_CNT_W-1:0] tb_count;
   logic                   tb_ok;
   logic                   cur_ok;

   assign req_full = cmd_full || ((wr_ptr_ff - rd_ptr) == RING_PTR_W'(RING_DEPTH));
   assign accept   = req_push && !req_full;
   assign c        = req_word.in_byte;
   assign is_let   = is_letter(c);
   assign is_ld    = is_let || is_digit(c);
   assign is_dot   = c == DOT_CHAR;
   assign room     = count_ff < LABEL_CNT_W'(MAX_LABEL);
   assign tb_bad   = bad_ff || !room ||
                     ((count_ff == '0) ? !is_let : (!is_ld && c != HYPHEN_CHAR));
   assign tb_count = room ? count_ff + LABEL_CNT_W'(1) : count_ff;
   assign tb_ok    = !tb_bad && is_ld;
   assign cur_ok   = count_ff != '0 && !bad_ff && lastld_ff;

   always_comb begin
      count_in  = count_ff;
      bad_in    = bad_ff;
      lastld_in = lastld_ff;
      sticky_in = sticky_ff;
      wr_ptr_in = wr_ptr_ff;
      start_in  = start_ff;
      cmd_push  = 1'b0;
      cmd       = '{len: count_ff, is_final: 1'b0, err: 1'b0};
      wr        = '{en: 1'b0, addr: wr_ptr_ff[RING_AW-1:0], data: c};
      if (accept) begin
         priority if (!req_word.in_last && is_dot) begin
            if (cur_ok) begin
               cmd_push = 1'b1;
               start_in = wr_ptr_ff;
            end else begin
               sticky_in = 1'b1;
               wr_ptr_in = start_ff;
            end
            count_in  = '0;
            bad_in    = 1'b0;
            lastld_in = 1'b0;
         end else if (!req_word.in_last) begin
            count_in  = tb_count;
            bad_in    = tb_bad;
            lastld_in = is_ld;
            if (room) begin
               wr.en     = 1'b1;
               wr_ptr_in = wr_ptr_ff + RING_PTR_W'(1);
            end
         end else begin
            cmd_push = 1'b1;
            if (is_dot || sticky_ff || !tb_ok) begin
               cmd       = '{len: '0, is_final: 1'b1, err: 1'b1};
               wr_ptr_in = start_ff;
            end else begin
               cmd       = '{len: tb_count, is_final: 1'b1, err: 1'b0};
               wr.en     = 1'b1;
               wr_ptr_in = wr_ptr_ff + RING_PTR_W'(1);
               start_in  = wr_ptr_ff + RING_PTR_W'(1);
            end
            count_in  = '0;
            bad_in    = 1'b0;
            lastld_in = 1'b0;
            sticky_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         bad_ff    <= 1'b0;
         lastld_ff <= 1'b0;
         sticky_ff <= 1'b0;
         wr_ptr_ff <= '0;
         start_ff  <= '0;
      end else begin
         count_ff  <= count_in;
         bad_ff    <= bad_in;
         lastld_ff <= lastld_in;
         sticky_ff <= sticky_in;
         wr_ptr_ff <= wr_ptr_in;
         start_ff  <= start_in;
      end
   end

endmodule

[sv/dnle_back.sv]
// Back end: replays each accepted label as a length byte and its characters, or gives an error word.
module dnle_back
   import dnle_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_empty,
   input  dnle_cmd_type          cmd,
   output logic                  cmd_pop,
   output logic [RING_PTR_W-1:0] rd_ptr,
   output logic [RING_AW-1:0]    rd_addr,
   input  logic [7:0]            rd_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output dnle_rsp_type          rsp_word
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_HEAD = 3'b010,
      ST_BODY = 3'b100
   } dnle_state_type;

   dnle_state_type         state_ff, state_in;
   dnle_cmd_type           cur_ff, cur_in;
   logic [LABEL_CNT_W-1:0] remain_ff, remain_in;
   logic [RING_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic                   out_valid_ff, out_valid_in;
   dnle_rsp_type           out_word_ff, out_word_in;
   logic                   slot_free;
   logic                   load;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign cmd_pop   = (state_ff == ST_IDLE) && !cmd_empty;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      remain_in   = remain_ff;
      rd_ptr_in   = rd_ptr_ff;
      load        = 1'b0;
      out_word_in = out_word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cur_in   = cmd;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (slot_free) begin
               load = 1'b1;
               if (cur_ff.err) begin
                  out_word_in = '{out_byte: 8'h00, out_last: 1'b1, name_error: 1'b1};
                  state_in    = ST_IDLE;
               end else begin
                  out_word_in = '{out_byte: 8'(cur_ff.len), out_last: 1'b0,
                                  name_error: 1'b0};
                  remain_in   = cur_ff.len;
                  state_in    = ST_BODY;
               end
            end
         end
         ST_BODY: begin
            if (slot_free) begin
               load        = 1'b1;
               out_word_in = '{out_byte: rd_data,
                               out_last: cur_ff.is_final && remain_ff == LABEL_CNT_W'(1),
                               name_error: 1'b0};
               rd_ptr_in   = rd_ptr_ff + RING_PTR_W'(1);
               remain_in   = remain_ff - LABEL_CNT_W'(1);
               if (remain_ff == LABEL_CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ptr_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      remain_ff   <= remain_in;
      out_word_ff <= out_word_in;
   end

   assign rd_ptr    = rd_ptr_ff;
   assign rd_addr   = rd_ptr_in[RING_AW-1:0];
   assign rsp_empty = !out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

[sv/dnle_checker.sv]
// Port-level checker for the label encoder and its bind to the top level.
`include "dns_name_label_encoder_core_assert.svh"

module dnle_checker
   import dnle_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_full,
   input logic         rsp_empty,
   input logic         rsp_pop,
   input dnle_rsp_type rsp_word
);

   `DNLE_ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, rsp_empty, "Result word present after reset.")
   `DNLE_ASSERT_NEXT(a_ready_after_reset, clock, 1'b0, reset, !req_full, "Input full after reset.")
   `DNLE_ASSERT_NOW(a_error_word_form, clock, reset, !rsp_empty && rsp_word.name_error, rsp_word.out_last && rsp_word.out_byte == 8'h00, "Error word is not a final zero word.")
   `DNLE_ASSERT_NEXT(a_stalled_word_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_word), "Stalled result word changed.")

endmodule

bind dns_name_label_encoder_core dnle_checker u_checker (.*);

[sim/dns_name_label_encoder_core_checker.sv]
// Checker of the DNS name label encoder: predicts the wire form of every name and compares it.
`timescale 1ns / 100ps
module dns_name_label_encoder_core_checker
   import dnle_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  logic         req_full,
   input  dnle_req_type req_word,
   input  logic         rsp_empty,
   input  logic         rsp_pop,
   input  dnle_rsp_type rsp_word,
   output int unsigned  fault_count,
   output int unsigned  words_pending,
   output int unsigned  words_checked,
   output int unsigned  names_closed,
   output int unsigned  names_failed,
   output int unsigned  full_stalls
);

   dnle_rsp_type wire_expect_q[$];
   logic [7:0]   label_chars[MAX_LABEL];
   int unsigned  label_len;
   logic         ends_let_dig;
   logic         label_broken;
   logic         name_broken;

   function automatic logic char_is_alpha(input logic [7:0] c);
      logic [7:0] upper;
      upper = c & 8'hDF;
      return upper >= 8'h41 && upper <= 8'h5A;
   endfunction

   function automatic logic char_is_num(input logic [7:0] c);
      return c[7:4] == 4'h3 && c[3:0] <= 4'd9;
   endfunction

   function automatic logic label_fits();
      return label_len != 0 && !label_broken && ends_let_dig;
   endfunction

   task automatic clear_label();
      label_len    = 0;
      ends_let_dig = 1'b0;
      label_broken = 1'b0;
   endtask

   task automatic take_char(input logic [7:0] c);
      logic alpha;
      logic alnum;
      alpha = char_is_alpha(c);
      alnum = alpha || char_is_num(c);
      if (label_len == 0) begin
         if (!alpha)
            label_broken = 1'b1;
      end else if (!alnum && c != HYPHEN_CHAR) begin
         label_broken = 1'b1;
      end
      // Characters past the longest legal label are dropped but spoil the label.
      if (label_len >= MAX_LABEL) begin
         label_broken = 1'b1;
      end else begin
         label_chars[label_len] = c;
         label_len++;
      end
      ends_let_dig = alnum;
   endtask

   task automatic put_word(input logic [7:0] b, input logic last, input logic err);
      dnle_rsp_type w;
      w.out_byte   = b;
      w.out_last   = last;
      w.name_error = err;
      wire_expect_q.insert(wire_expect_q.size(), w);
   endtask

   task automatic queue_label(input logic final_label);
      put_word(8'(label_len), 1'b0, 1'b0);
      for (int unsigned i = 0; i < label_len; i++)
         put_word(label_chars[i], final_label && (i + 1 == label_len), 1'b0);
   endtask

   task automatic predict_name_word(input dnle_req_type w);
      if (!w.in_last) begin
         if (w.in_byte == DOT_CHAR) begin
            if (label_fits())
               queue_label(1'b0);
            else
               name_broken = 1'b1;
            clear_label();
         end else begin
            take_char(w.in_byte);
         end
      end else begin
         // A final dot leaves an empty last label, so the name always fails.
         if (w.in_byte == DOT_CHAR) begin
            name_broken = 1'b1;
         end else begin
            take_char(w.in_byte);
            if (!label_fits())
               name_broken = 1'b1;
         end
         names_closed++;
         if (name_broken) begin
            put_word(8'h00, 1'b1, 1'b1);
            names_failed++;
         end else begin
            queue_label(1'b1);
         end
         clear_label();
         name_broken = 1'b0;
      end
   endtask

   task automatic check_word(input dnle_rsp_type got);
      dnle_rsp_type want;
      words_checked++;
      if (wire_expect_q.size() == 0) begin
         fault_count++;
         if (fault_count <= 10)
            $display("%0t: unexpected word: byte %02h last %0b error %0b", $realtime,
                     got.out_byte, got.out_last, got.name_error);
      end else begin
         want = wire_expect_q.pop_front();
         if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
             got.name_error !== want.name_error) begin
            fault_count++;
            if (fault_count <= 10)
               $display("%0t: word %0d: expected byte %02h last %0b error %0b, got byte %02h last %0b error %0b",
                        $realtime, words_checked, want.out_byte, want.out_last,
                        want.name_error, got.out_byte, got.out_last, got.name_error);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wire_expect_q.delete();
         clear_label();
         name_broken   = 1'b0;
         fault_count   = 0;
         words_checked = 0;
         names_closed  = 0;
         names_failed  = 0;
         full_stalls   = 0;
      end else begin
         if (req_push && req_full)
            full_stalls++;
         if (req_push && !req_full)
            predict_name_word(req_word);
         if (rsp_pop && !rsp_empty)
            check_word(rsp_word);
      end
      words_pending <= wire_expect_q.size();
   end

endmodule

[sim/dns_name_label_encoder_core_test.sv]
// Testbench top of the DNS name label encoder: drives dotted names, drains results, gives the verdict.
`timescale 1ns / 100ps
module dns_name_label_encoder_core_test;
   import dnle_pkg::*;

   localparam int unsigned RANDOM_BYTES  = 256;
   localparam int unsigned DRAIN_LIMIT   = 100000;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned HOLD_CYCLES   = 600;

   typedef enum int {
      LBL_GOOD,
      LBL_EMPTY,
      LBL_BAD_START,
      LBL_BAD_END,
      LBL_BAD_CHAR,
      LBL_LONG
   } label_kind_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_push;
   logic         req_full;
   dnle_req_type req_word;
   logic         rsp_empty;
   logic         rsp_pop;
   dnle_rsp_type rsp_word;

   int unsigned  fault_count;
   int unsigned  words_pending;
   int unsigned  words_checked;
   int unsigned  names_closed;
   int unsigned  names_failed;
   int unsigned  full_stalls;

   logic         tx_no_idle = 1'b0;
   logic         rx_no_idle = 1'b0;
   logic         drain_stuck = 1'b0;
   int unsigned  rx_hold_req = 0;
   int unsigned  bytes_sent = 0;
   logic [7:0]   name_chars[$];

   dns_name_label_encoder_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   dns_name_label_encoder_core_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_word      (req_word),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_word      (rsp_word),
      .fault_count   (fault_count),
      .words_pending (words_pending),
      .words_checked (words_checked),
      .names_closed  (names_closed),
      .names_failed  (names_failed),
      .full_stalls   (full_stalls)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("Run did not finish in time.");
      $display("TEST FAILED");
      $finish;
   end

   function automatic int unsigned draw_gap(input logic no_idle);
      if (no_idle || $urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, 13);
   endfunction

   function automatic logic [7:0] rand_letter();
      if ($urandom_range(0, 1) == 0)
         return 8'h41 + 8'($urandom_range(0, 25));
      return 8'h61 + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'h30 + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_alnum();
      if ($urandom_range(0, 3) == 0)
         return rand_digit();
      return rand_letter();
   endfunction

   function automatic logic [7:0] rand_inner();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick == 0)
         return HYPHEN_CHAR;
      if (pick <= 2)
         return rand_digit();
      return rand_letter();
   endfunction

   // Anything outside letters, digits, hyphen and dot, spread over the whole byte range.
   function automatic logic [7:0] rand_bad_char();
      case ($urandom_range(0, 4))
         0: begin
            return 8'($urandom_range(8'h00, 8'h2C));
         end
         1: begin
            return 8'h2F;
         end
         2: begin
            return 8'($urandom_range(8'h3A, 8'h40));
         end
         3: begin
            return 8'($urandom_range(8'h5B, 8'h60));
         end
         default: begin
            return 8'($urandom_range(8'h7B, 8'hFF));
         end
      endcase
   endfunction

   function automatic int unsigned rand_len();
      if ($urandom_range(0, 11) == 0)
         return $urandom_range(9, MAX_LABEL);
      return $urandom_range(1, 8);
   endfunction

   task automatic send_byte(input logic [7:0] c, input logic last);
      int unsigned  gap;
      dnle_req_type w;
      gap = draw_gap(tx_no_idle);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      w.in_byte = c;
      w.in_last = last;
      req_word <= w;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   task automatic send_name();
      for (int unsigned i = 0; i < name_chars.size(); i++)
         send_byte(name_chars[i], i + 1 == name_chars.size());
   endtask

   task automatic append_char(input logic [7:0] c);
      name_chars.insert(name_chars.size(), c);
   endtask

   task automatic send_text(input string s);
      name_chars.delete();
      for (int i = 0; i < s.len(); i++)
         append_char(s[i]);
      send_name();
   endtask

   task automatic add_label(input label_kind_type kind, input int unsigned len);
      int unsigned first;
      int unsigned n;
      first = name_chars.size();
      n = len;
      case (kind)
         LBL_EMPTY: begin
         end
         LBL_BAD_START: begin
            append_char($urandom_range(0, 1) ? rand_digit() : HYPHEN_CHAR);
            for (int unsigned i = 1; i < n; i++)
               append_char(rand_inner());
         end
         LBL_BAD_END: begin
            append_char(rand_letter());
            for (int unsigned i = 2; i < n; i++)
               append_char(rand_inner());
            append_char(HYPHEN_CHAR);
         end
         default: begin
            if (kind == LBL_LONG)
               n = $urandom_range(MAX_LABEL + 1, MAX_LABEL + 3);
            append_char(rand_letter());
            for (int unsigned i = 1; i + 1 < n; i++)
               append_char(rand_inner());
            if (n > 1)
               append_char(rand_alnum());
            if (kind == LBL_BAD_CHAR)
               name_chars[first + $urandom_range(0, n - 1)] = rand_bad_char();
         end
      endcase
   endtask

   // Mostly well-formed names; about one in four carries a single broken label.
   task automatic add_random_name();
      int unsigned labels;
      int unsigned broken_at;
      label_kind_type kind;
      name_chars.delete();
      labels = $urandom_range(1, 4);
      broken_at = labels;
      if ($urandom_range(0, 3) == 0)
         broken_at = $urandom_range(0, labels - 1);
      for (int unsigned i = 0; i < labels; i++) begin
         if (i > 0)
            append_char(DOT_CHAR);
         kind = LBL_GOOD;
         if (i == broken_at) begin
            kind = label_kind_type'($urandom_range(1, 5));
            if (kind == LBL_LONG && $urandom_range(0, 3) != 0)
               kind = LBL_BAD_CHAR;
         end
         add_label(kind, rand_len());
      end
      if ($urandom_range(0, 19) == 0 || name_chars.size() == 0)
         append_char(DOT_CHAR);
   endtask

   task automatic send_random_until(input int unsigned target);
      while (bytes_sent < target) begin
         add_random_name();
         send_name();
         if ($urandom_range(0, 9) == 0)
            tx_no_idle = !tx_no_idle;
         if ($urandom_range(0, 9) == 0)
            rx_no_idle = !rx_no_idle;
      end
   endtask

   task automatic pause_until_drained();
      int unsigned cycles;
      cycles = 0;
      req_push <= 1'b0;
      do begin
         @(posedge clock);
         cycles++;
      end while (words_pending != 0 && cycles < DRAIN_LIMIT);
      if (words_pending != 0)
         drain_stuck = 1'b1;
   endtask

   initial begin : word_sink
      int unsigned gap;
      gap = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty)
            gap = draw_gap(rx_no_idle);
         if (rx_hold_req != 0) begin
            gap += rx_hold_req;
            rx_hold_req = 0;
         end
         if (reset || gap > 0) begin
            rsp_pop <= 1'b0;
            if (gap > 0)
               gap--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin : name_source
      int unsigned random_start;
      reset    <= 1'b1;
      req_push <= 1'b0;
      req_word <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_text("a");
      send_text(".");
      send_text("z-9.Q0");
      send_text("-a");
      send_text("ab-");
      send_text("9");
      send_text("a..b");
      send_text("A.");
      name_chars.delete();
      append_char(8'h61);
      append_char(8'hFF);
      send_name();
      name_chars.delete();
      append_char(8'h00);
      send_name();
      pause_until_drained();

      name_chars.delete();
      add_label(LBL_GOOD, MAX_LABEL);
      send_name();
      name_chars.delete();
      add_label(LBL_GOOD, MAX_LABEL + 1);
      append_char(DOT_CHAR);
      add_label(LBL_GOOD, 2);
      send_name();

      random_start = bytes_sent;
      send_random_until(random_start + 80);

      // The result side stops for a long stretch while names keep coming at full rate.
      pause_until_drained();
      rx_hold_req = HOLD_CYCLES;
      tx_no_idle  = 1'b1;
      send_random_until(random_start + 200);
      tx_no_idle  = 1'b0;

      pause_until_drained();
      send_random_until(random_start + RANDOM_BYTES);

      rx_no_idle = 1'b1;
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d name bytes in %0d names, %0d of them with a broken label.",
               bytes_sent, names_closed, names_failed);
      $display("Checked %0d result words; input held off for %0d cycles.",
               words_checked, full_stalls);
      if (words_pending != 0)
         $display("%0d expected words never arrived.", words_pending);
      if (fault_count == 0 && words_pending == 0 && !drain_stuck)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
